FILE: rtl/core/slir_pkg.sv
// Shared widths, defaults and the lane control type of the stereo resampler.
package slir_pkg;

    localparam int FRAC_BITS_DEF   = 12;
    localparam int SAMPLE_BITS_DEF = 16;

    localparam int SAMPLE_W = 16;
    localparam int STEP_W   = 14;
    localparam int GAIN_W   = 16;
    localparam int OUT_W    = 32;
    localparam int ACC_W    = SAMPLE_W + 1;

    localparam logic [SAMPLE_W-1:0] OFFSET_RESET = 16'd32768;

    typedef struct packed {
        logic load;
        logic mix_step;
        logic scale_start;
        logic scale_step;
    } lane_ctl_t;

endpackage

FILE: rtl/core/stereo_linear_interp_resampler.sv
// Top level of the stereo linear-interpolation resampler with volume gain.
//
//   Channel  Direction  Handshake            Request contents
//   s_       in         s_valid / s_ready    left, right sample, pitch step, gain, stream end
//   m_       out        m_valid / m_ready    left, right output, run last flag
//   cfg_     in         cfg_valid/cfg_ready  silence offset
//
// A priming request, or one whose fraction is already at one, stays in the idle state.
// Each output pair is computed by the bit-serial interpolation and gain loops in the
// channel lanes; a new request is taken only once the last pair of the current one has been
// stored in the output register.
// Reset is synchronous and active low; it unprimes the stream and sets the offset to 32768.
// While m_ready is low one pair is held, and the next pair is computed and waits behind it.
module stereo_linear_interp_resampler #(
    parameter int FRAC_BITS   = slir_pkg::FRAC_BITS_DEF,
    parameter int SAMPLE_BITS = slir_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic        [slir_pkg::SAMPLE_W-1:0] s_left_sample,
    input  logic        [slir_pkg::SAMPLE_W-1:0] s_right_sample,
    input  logic        [slir_pkg::STEP_W-1:0]   s_pitch_step,
    input  logic        [slir_pkg::GAIN_W-1:0]   s_volume_gain,
    input  logic                                 s_stream_end,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic        [slir_pkg::SAMPLE_W-1:0] cfg_data,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [slir_pkg::OUT_W-1:0]    m_left_out,
    output logic signed [slir_pkg::OUT_W-1:0]    m_right_out,
    output logic                                 m_run_last
);
    import slir_pkg::*;

    lane_ctl_t                lane_ctl;
    logic [SAMPLE_W-1:0]      l_prev, l_next, r_prev, r_next, offset;
    logic [FRAC_BITS-1:0]     frac;
    logic [GAIN_W-1:0]        gain;
    logic signed [OUT_W-1:0]  l_result, r_result;

    slir_seq #(
        .FRAC_BITS   (FRAC_BITS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_seq (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_left_sample  (s_left_sample),
        .s_right_sample (s_right_sample),
        .s_pitch_step   (s_pitch_step),
        .s_volume_gain  (s_volume_gain),
        .s_stream_end   (s_stream_end),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_left_out     (m_left_out),
        .m_right_out    (m_right_out),
        .m_run_last     (m_run_last),
        .lane_ctl       (lane_ctl),
        .l_prev         (l_prev),
        .l_next         (l_next),
        .r_prev         (r_prev),
        .r_next         (r_next),
        .offset         (offset),
        .frac           (frac),
        .gain           (gain),
        .l_result       (l_result),
        .r_result       (r_result)
    );

    slir_lane #(
        .FRAC_BITS (FRAC_BITS)
    ) u_lane_left (
        .aclk   (aclk),
        .ctl    (lane_ctl),
        .prev   (l_prev),
        .next   (l_next),
        .offset (offset),
        .frac   (frac),
        .gain   (gain),
        .result (l_result)
    );

    slir_lane #(
        .FRAC_BITS (FRAC_BITS)
    ) u_lane_right (
        .aclk   (aclk),
        .ctl    (lane_ctl),
        .prev   (r_prev),
        .next   (r_next),
        .offset (offset),
        .frac   (frac),
        .gain   (gain),
        .result (r_result)
    );

endmodule

FILE: rtl/core/slir_lane.sv
// One channel of the resampler: bit-serial interpolation followed by bit-serial gain scaling.
module slir_lane #(
    parameter int FRAC_BITS = slir_pkg::FRAC_BITS_DEF
) (
    input  logic                                 aclk,
    input  slir_pkg::lane_ctl_t                  ctl,
    input  logic        [slir_pkg::SAMPLE_W-1:0] prev,
    input  logic        [slir_pkg::SAMPLE_W-1:0] next,
    input  logic        [slir_pkg::SAMPLE_W-1:0] offset,
    input  logic        [FRAC_BITS-1:0]          frac,
    input  logic        [slir_pkg::GAIN_W-1:0]   gain,
    output logic signed [slir_pkg::OUT_W-1:0]    result
);
    import slir_pkg::*;

    localparam int SUM_W = ACC_W + 2;
    localparam int SR_W  = ACC_W + FRAC_BITS;
    localparam int RES_W = GAIN_W + 3;

    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic signed [ACC_W-1:0]  base_reg, base_next;
    logic signed [ACC_W-1:0]  diff_reg, diff_next;
    logic        [FRAC_BITS-1:0] frac_reg, frac_next;
    logic        [SR_W-1:0]   sr_reg, sr_next;
    logic                     neg_reg, neg_next;
    logic                     seen_reg, seen_next;
    logic        [GAIN_W-1:0] hi_reg, hi_next;
    logic        [1:0]        lo_reg, lo_next;

    logic signed [SUM_W-1:0]  mix_sum;
    logic signed [ACC_W-1:0]  mix_hi;
    logic                     scale_bit;
    logic        [GAIN_W:0]   scale_sum;
    logic        [RES_W-1:0]  res;

    assign mix_sum = {{2{acc_reg[ACC_W-1]}}, acc_reg}
                   + (frac_reg[0] ? {{2{diff_reg[ACC_W-1]}}, diff_reg} : '0);
    assign mix_hi = acc_reg + base_reg;
    assign scale_bit = neg_reg ? (sr_reg[0] ^ seen_reg) : sr_reg[0];
    assign scale_sum = {1'b0, hi_reg} + (scale_bit ? {1'b0, gain} : '0);
    assign res = neg_reg ? (RES_W'(0) - {1'b0, hi_reg, lo_reg}) : {1'b0, hi_reg, lo_reg};
    assign result = {{(OUT_W - RES_W){res[RES_W-1]}}, res};

    always_comb begin
        acc_next  = acc_reg;
        base_next = base_reg;
        diff_next = diff_reg;
        frac_next = frac_reg;
        sr_next   = sr_reg;
        neg_next  = neg_reg;
        seen_next = seen_reg;
        hi_next   = hi_reg;
        lo_next   = lo_reg;
        if (ctl.load) begin
            acc_next  = '0;
            base_next = {1'b0, prev} - {1'b0, offset};
            diff_next = {1'b0, next} - {1'b0, prev};
            frac_next = frac;
        end
        if (ctl.mix_step) begin
            acc_next  = mix_sum[ACC_W:1];
            frac_next = {mix_sum[0], frac_reg[FRAC_BITS-1:1]};
        end
        if (ctl.scale_start) begin
            sr_next   = {mix_hi, frac_reg};
            neg_next  = mix_hi[ACC_W-1];
            seen_next = 1'b0;
            hi_next   = '0;
            lo_next   = '0;
        end
        if (ctl.scale_step) begin
            sr_next   = {1'b0, sr_reg[SR_W-1:1]};
            seen_next = seen_reg | sr_reg[0];
            hi_next   = scale_sum[GAIN_W:1];
            lo_next   = {scale_sum[0], lo_reg[1]};
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg  <= acc_next;
        base_reg <= base_next;
        diff_reg <= diff_next;
        frac_reg <= frac_next;
        sr_reg   <= sr_next;
        neg_reg  <= neg_next;
        seen_reg <= seen_next;
        hi_reg   <= hi_next;
        lo_reg   <= lo_next;
    end

endmodule

FILE: rtl/core/slir_seq.sv
// Sequencer of the resampler: stream priming, fraction tracking, lane control and output register.
module slir_seq #(
    parameter int FRAC_BITS   = slir_pkg::FRAC_BITS_DEF,
    parameter int SAMPLE_BITS = slir_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic        [slir_pkg::SAMPLE_W-1:0] s_left_sample,
    input  logic        [slir_pkg::SAMPLE_W-1:0] s_right_sample,
    input  logic        [slir_pkg::STEP_W-1:0]   s_pitch_step,
    input  logic        [slir_pkg::GAIN_W-1:0]   s_volume_gain,
    input  logic                                 s_stream_end,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic        [slir_pkg::SAMPLE_W-1:0] cfg_data,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [slir_pkg::OUT_W-1:0]    m_left_out,
    output logic signed [slir_pkg::OUT_W-1:0]    m_right_out,
    output logic                                 m_run_last,
    output slir_pkg::lane_ctl_t                  lane_ctl,
    output logic        [slir_pkg::SAMPLE_W-1:0] l_prev,
    output logic        [slir_pkg::SAMPLE_W-1:0] l_next,
    output logic        [slir_pkg::SAMPLE_W-1:0] r_prev,
    output logic        [slir_pkg::SAMPLE_W-1:0] r_next,
    output logic        [slir_pkg::SAMPLE_W-1:0] offset,
    output logic        [FRAC_BITS-1:0]          frac,
    output logic        [slir_pkg::GAIN_W-1:0]   gain,
    input  logic signed [slir_pkg::OUT_W-1:0]    l_result,
    input  logic signed [slir_pkg::OUT_W-1:0]    r_result
);
    import slir_pkg::*;

    localparam int PW          = ((FRAC_BITS > STEP_W) ? FRAC_BITS : STEP_W) + 1;
    localparam int SCALE_STEPS = SAMPLE_W + FRAC_BITS;
    localparam int CW          = $clog2(SCALE_STEPS);

    localparam logic [PW-1:0]       ONE_POS  = PW'(1) << FRAC_BITS;
    localparam logic [STEP_W-1:0]   MIN_STEP = STEP_W'(1) << (FRAC_BITS - 6);
    localparam logic [SAMPLE_W-1:0] SAMPLE_MASK = (SAMPLE_BITS >= SAMPLE_W) ? '1 :
                                      SAMPLE_W'((32'd1 << SAMPLE_BITS) - 32'd1);

    localparam logic [1:0] FILL_EMPTY  = 2'd0;
    localparam logic [1:0] FILL_HALF   = 2'd1;
    localparam logic [1:0] FILL_PRIMED = 2'd2;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_LOAD  = 6'b000010,
        S_MIX   = 6'b000100,
        S_PREP  = 6'b001000,
        S_SCALE = 6'b010000,
        S_DONE  = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic [1:0]          fill_reg, fill_next;
    logic [PW-1:0]       pos_reg, pos_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic [SAMPLE_W-1:0] offset_reg, offset_next;
    logic [SAMPLE_W-1:0] pl_reg, pl_next, pr_reg, pr_next;
    logic [SAMPLE_W-1:0] nl_reg, nl_next, nr_reg, nr_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [GAIN_W-1:0]   gain_reg, gain_next;
    logic                last_reg, last_next;
    logic                m_valid_reg, m_valid_next;
    logic [OUT_W-1:0]    lo_reg, lo_next, ro_reg, ro_next;
    logic                rl_reg, rl_next;

    logic [SAMPLE_W-1:0] ls, rs;
    logic [PW-1:0]       pos_step;
    logic                pair_last;

    assign ls        = s_left_sample & SAMPLE_MASK;
    assign rs        = s_right_sample & SAMPLE_MASK;
    assign pos_step  = pos_reg + {{(PW - STEP_W){1'b0}}, step_reg};
    assign pair_last = pos_step >= ONE_POS;

    assign s_ready     = (state_reg == S_IDLE);
    assign cfg_ready   = 1'b1;
    assign m_valid     = m_valid_reg;
    assign m_left_out  = lo_reg;
    assign m_right_out = ro_reg;
    assign m_run_last  = rl_reg;
    assign l_prev      = pl_reg;
    assign l_next      = nl_reg;
    assign r_prev      = pr_reg;
    assign r_next      = nr_reg;
    assign offset      = offset_reg;
    assign frac        = pos_reg[FRAC_BITS-1:0];
    assign gain        = gain_reg;

    always_comb begin
        state_next   = state_reg;
        fill_next    = fill_reg;
        pos_next     = pos_reg;
        cnt_next     = cnt_reg;
        offset_next  = offset_reg;
        pl_next      = pl_reg;
        pr_next      = pr_reg;
        nl_next      = nl_reg;
        nr_next      = nr_reg;
        step_next    = step_reg;
        gain_next    = gain_reg;
        last_next    = last_reg;
        m_valid_next = m_valid_reg;
        lo_next      = lo_reg;
        ro_next      = ro_reg;
        rl_next      = rl_reg;
        lane_ctl     = '0;

        if (cfg_valid) begin
            offset_next = cfg_data;
        end
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    step_next = (s_pitch_step < MIN_STEP) ? MIN_STEP : s_pitch_step;
                    gain_next = s_volume_gain;
                    last_next = s_stream_end;
                    case (fill_reg)
                        FILL_EMPTY: begin
                            pl_next   = ls;
                            pr_next   = rs;
                            fill_next = s_stream_end ? FILL_EMPTY : FILL_HALF;
                        end
                        FILL_HALF: begin
                            nl_next   = ls;
                            nr_next   = rs;
                            fill_next = s_stream_end ? FILL_EMPTY : FILL_PRIMED;
                        end
                        default: begin
                            pl_next = nl_reg;
                            pr_next = nr_reg;
                            nl_next = ls;
                            nr_next = rs;
                            if (pos_reg < ONE_POS) begin
                                state_next = S_LOAD;
                            end else begin
                                pos_next = pos_reg - ONE_POS;
                                if (s_stream_end) begin
                                    fill_next = FILL_EMPTY;
                                    pos_next  = '0;
                                end
                            end
                        end
                    endcase
                end
            end
            S_LOAD: begin
                lane_ctl.load = 1'b1;
                cnt_next      = '0;
                state_next    = S_MIX;
            end
            S_MIX: begin
                lane_ctl.mix_step = 1'b1;
                cnt_next          = cnt_reg + CW'(1);
                if (cnt_reg == CW'(FRAC_BITS - 1)) begin
                    state_next = S_PREP;
                end
            end
            S_PREP: begin
                lane_ctl.scale_start = 1'b1;
                cnt_next             = '0;
                state_next           = S_SCALE;
            end
            S_SCALE: begin
                lane_ctl.scale_step = 1'b1;
                cnt_next            = cnt_reg + CW'(1);
                if (cnt_reg == CW'(SCALE_STEPS - 1)) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    lo_next      = l_result;
                    ro_next      = r_result;
                    rl_next      = pair_last;
                    if (pair_last) begin
                        pos_next   = pos_step - ONE_POS;
                        state_next = S_IDLE;
                        if (last_reg) begin
                            fill_next = FILL_EMPTY;
                            pos_next  = '0;
                        end
                    end else begin
                        pos_next   = pos_step;
                        state_next = S_LOAD;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            fill_reg    <= FILL_EMPTY;
            pos_reg     <= '0;
            cnt_reg     <= '0;
            offset_reg  <= OFFSET_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            pos_reg     <= pos_next;
            cnt_reg     <= cnt_next;
            offset_reg  <= offset_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pl_reg   <= pl_next;
        pr_reg   <= pr_next;
        nl_reg   <= nl_next;
        nr_reg   <= nr_next;
        step_reg <= step_next;
        gain_reg <= gain_next;
        last_reg <= last_next;
        lo_reg   <= lo_next;
        ro_reg   <= ro_next;
        rl_reg   <= rl_next;
    end

endmodule

FILE: rtl/core/slir_checker.sv
// Port-level assertions of the resampler and the bind that attaches them to the top level.
module slir_checker (
    input logic                                 aclk,
    input logic                                 aresetn,
    input logic                                 s_valid,
    input logic                                 s_ready,
    input logic        [slir_pkg::SAMPLE_W-1:0] s_left_sample,
    input logic        [slir_pkg::SAMPLE_W-1:0] s_right_sample,
    input logic        [slir_pkg::STEP_W-1:0]   s_pitch_step,
    input logic        [slir_pkg::GAIN_W-1:0]   s_volume_gain,
    input logic                                 s_stream_end,
    input logic                                 cfg_valid,
    input logic                                 cfg_ready,
    input logic        [slir_pkg::SAMPLE_W-1:0] cfg_data,
    input logic                                 m_valid,
    input logic                                 m_ready,
    input logic signed [slir_pkg::OUT_W-1:0]    m_left_out,
    input logic signed [slir_pkg::OUT_W-1:0]    m_right_out,
    input logic                                 m_run_last
);
    import slir_pkg::*;

    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && !s_ready) |=> (s_valid && $stable(s_left_sample)
                                   && $stable(s_right_sample) && $stable(s_pitch_step)
                                   && $stable(s_volume_gain) && $stable(s_stream_end)))
        else $error("input request changed while waiting");

    a_cfg_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (cfg_valid && !cfg_ready) |=> (cfg_valid && $stable(cfg_data)))
        else $error("configuration request changed while waiting");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_left_out) && $stable(m_right_out)
                                   && $stable(m_run_last)))
        else $error("result request changed while stalled");

    a_idle_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_ready && !m_valid) |=> !m_valid)
        else $error("result appeared straight from the idle state");

    a_out_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (((m_left_out[OUT_W-1:18] == '0) || (m_left_out[OUT_W-1:18] == '1))
                     && ((m_right_out[OUT_W-1:18] == '0) || (m_right_out[OUT_W-1:18] == '1))))
        else $error("output beyond the reachable range");

endmodule

bind stereo_linear_interp_resampler slir_checker u_slir_checker (.*);

FILE: sim/stereo_linear_interp_resampler_tb.sv
// Self-checking testbench of the stereo linear-interpolation resampler with volume gain.
`timescale 1ns / 1ps

module stereo_linear_interp_resampler_tb;

    import slir_pkg::*;

    localparam int FRAC_BITS     = FRAC_BITS_DEF;
    localparam int UNITY_POS     = 1 << FRAC_BITS;
    localparam int MIN_STEP      = UNITY_POS >> 6;
    localparam int MAX_PAIRS     = 64;
    localparam int GAIN_FRAC     = 14;
    localparam int PAIR_CYCLES   = 2 * FRAC_BITS + 19;
    localparam int SETTLE_CYCLES = 4 * PAIR_CYCLES;
    localparam int HOLD_CYCLES   = 3000;
    localparam int QUIET_LIMIT   = 20000;

    typedef enum logic [1:0] {FILL_EMPTY, FILL_PREV, FILL_PRIMED} fill_lvl_t;

    typedef struct {
        logic signed [OUT_W-1:0] left;
        logic signed [OUT_W-1:0] right;
        logic                    is_end;
    } out_pair_t;

    logic                    aclk           = 1'b0;
    logic                    aresetn        = 1'b0;
    logic                    s_valid        = 1'b0;
    logic                    s_ready;
    logic [SAMPLE_W-1:0]     s_left_sample  = '0;
    logic [SAMPLE_W-1:0]     s_right_sample = '0;
    logic [STEP_W-1:0]       s_pitch_step   = '0;
    logic [GAIN_W-1:0]       s_volume_gain  = '0;
    logic                    s_stream_end   = 1'b0;
    logic                    cfg_valid      = 1'b0;
    logic                    cfg_ready;
    logic [SAMPLE_W-1:0]     cfg_data       = '0;
    logic                    m_valid;
    logic                    m_ready        = 1'b0;
    logic signed [OUT_W-1:0] m_left_out;
    logic signed [OUT_W-1:0] m_right_out;
    logic                    m_run_last;

    out_pair_t           pending_pairs[$];
    int                  error_count   = 0;
    int                  snd_idle_pct  = 0;
    int                  rcv_stall_pct = 0;
    int                  hold_order    = 0;
    int                  hold_seen     = 0;
    int                  hold_left     = 0;
    int                  quiet_cycles  = 0;

    logic [SAMPLE_W-1:0] silence_lvl = OFFSET_RESET;
    logic [SAMPLE_W-1:0] hist_prev_l = '0;
    logic [SAMPLE_W-1:0] hist_prev_r = '0;
    logic [SAMPLE_W-1:0] hist_next_l = '0;
    logic [SAMPLE_W-1:0] hist_next_r = '0;
    int unsigned         phase_acc   = 0;
    fill_lvl_t           fill_lvl    = FILL_EMPTY;

    stereo_linear_interp_resampler i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_left_sample  (s_left_sample),
        .s_right_sample (s_right_sample),
        .s_pitch_step   (s_pitch_step),
        .s_volume_gain  (s_volume_gain),
        .s_stream_end   (s_stream_end),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_left_out     (m_left_out),
        .m_right_out    (m_right_out),
        .m_run_last     (m_run_last)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic logic signed [OUT_W-1:0] mix_lane(input logic [SAMPLE_W-1:0] p,
                                                         input logic [SAMPLE_W-1:0] n,
                                                         input int unsigned frac,
                                                         input logic [GAIN_W-1:0] gain);
        longint a, b, f, g, num, den, v;
        a   = longint'(p);
        b   = longint'(n);
        f   = longint'(frac);
        g   = longint'(gain);
        den = longint'(UNITY_POS);
        den = den << GAIN_FRAC;
        a   = a - longint'(silence_lvl);
        b   = b - longint'(silence_lvl);
        num = a * (UNITY_POS - f) + b * f;
        v   = (num * g) / den;
        if (v > 64'sd2147483647) begin
            v = 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            v = -64'sd2147483648;
        end
        return v[OUT_W-1:0];
    endfunction

    task automatic advance_resampler(input logic [SAMPLE_W-1:0] ls, input logic [SAMPLE_W-1:0] rs,
                                     input logic [STEP_W-1:0] step_in,
                                     input logic [GAIN_W-1:0] gain, input logic is_last);
        int unsigned step;
        int          count;
        out_pair_t   pr;
        step = 32'(step_in);
        if (step < MIN_STEP) begin
            step = MIN_STEP;
        end
        case (fill_lvl)
            FILL_EMPTY: begin
                hist_prev_l = ls;
                hist_prev_r = rs;
                fill_lvl    = is_last ? FILL_EMPTY : FILL_PREV;
            end
            FILL_PREV: begin
                hist_next_l = ls;
                hist_next_r = rs;
                fill_lvl    = is_last ? FILL_EMPTY : FILL_PRIMED;
            end
            default: begin
                hist_prev_l = hist_next_l;
                hist_prev_r = hist_next_r;
                hist_next_l = ls;
                hist_next_r = rs;
                count = 0;
                while (phase_acc < UNITY_POS && count < MAX_PAIRS) begin
                    pr.left   = mix_lane(hist_prev_l, hist_next_l, phase_acc, gain);
                    pr.right  = mix_lane(hist_prev_r, hist_next_r, phase_acc, gain);
                    pr.is_end = (phase_acc + step >= UNITY_POS) || (count == MAX_PAIRS - 1);
                    pending_pairs.push_back(pr);
                    count++;
                    phase_acc += step;
                end
                if (phase_acc >= UNITY_POS) begin
                    phase_acc -= UNITY_POS;
                end else begin
                    phase_acc = 0;
                end
                if (is_last) begin
                    fill_lvl  = FILL_EMPTY;
                    phase_acc = 0;
                end
            end
        endcase
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("[%0t] mismatch on %s: got %0d, wanted %0d", $realtime, what, got, want);
        error_count++;
    endtask

    always @(posedge aclk) begin : check_pairs
        out_pair_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_pairs.size() == 0) begin
                report_mismatch("unrequested output pair", m_left_out, 0);
            end else begin
                want = pending_pairs.pop_front();
                if (m_left_out !== want.left) begin
                    report_mismatch("m_left_out", m_left_out, want.left);
                end
                if (m_right_out !== want.right) begin
                    report_mismatch("m_right_out", m_right_out, want.right);
                end
                if (m_run_last !== want.is_end) begin
                    report_mismatch("m_run_last", m_run_last, want.is_end);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (hold_order != hold_seen) begin
            hold_seen <= hold_order;
            hold_left <= HOLD_CYCLES;
            m_ready   <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= rcv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[%0t] no request accepted for %0d cycles", $realtime, QUIET_LIMIT);
            $display("** stereo_linear_interp_resampler: FAILED **");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_sample(input logic [SAMPLE_W-1:0] ls, input logic [SAMPLE_W-1:0] rs,
                               input logic [STEP_W-1:0] step, input logic [GAIN_W-1:0] gain,
                               input logic is_last);
        int gap;
        s_left_sample  <= ls;
        s_right_sample <= rs;
        s_pitch_step   <= step;
        s_volume_gain  <= gain;
        s_stream_end   <= is_last;
        s_valid        <= 1'b1;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        advance_resampler(ls, rs, step, gain, is_last);
        gap = 0;
        while (gap < 40 && $urandom_range(0, 99) < snd_idle_pct) begin
            gap++;
        end
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (pending_pairs.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_offset(input logic [SAMPLE_W-1:0] value);
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) begin
            @(posedge aclk);
        end
        cfg_valid   <= 1'b0;
        silence_lvl = value;
    endtask

    task automatic run_streams(input int n_items);
        int                sent, len, k, r;
        logic [GAIN_W-1:0] gain;
        logic [STEP_W-1:0] step;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(0, 99) < 85) begin
                len = $urandom_range(3, 10);
            end else begin
                len = $urandom_range(1, 2);
            end
            gain = ($urandom_range(0, 4) == 0) ? 16'd16384 : 16'($urandom_range(0, 65535));
            for (k = 0; k < len; k++) begin
                if ($urandom_range(0, 3) == 0) begin
                    gain = 16'($urandom_range(0, 65535));
                end
                r = $urandom_range(0, 99);
                if (r < 5) begin
                    step = 14'($urandom_range(0, 255));
                end else if (r < 30) begin
                    step = 14'($urandom_range(0, 16383));
                end else begin
                    step = 14'($urandom_range(1024, 16383));
                end
                send_sample(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)), step,
                            gain, k == len - 1);
            end
            sent += len;
        end
    endtask

    task automatic test_directed();
        snd_idle_pct  = 0;
        rcv_stall_pct = 0;
        send_sample(16'd0,     16'd65535, 14'd4096,  16'd16384, 1'b0);
        send_sample(16'd65535, 16'd0,     14'd4096,  16'd16384, 1'b0);
        send_sample(16'd32768, 16'd32768, 14'd4096,  16'd16384, 1'b0);
        send_sample(16'd65535, 16'd0,     14'd0,     16'd65535, 1'b0);
        send_sample(16'd0,     16'd65535, 14'd63,    16'd16384, 1'b0);
        send_sample(16'd12345, 16'd54321, 14'd2048,  16'd0,     1'b0);
        send_sample(16'd65535, 16'd65535, 14'd16383, 16'd65535, 1'b0);
        send_sample(16'd0,     16'd0,     14'd4096,  16'd65535, 1'b0);
        send_sample(16'd1,     16'd2,     14'd4096,  16'd32768, 1'b0);
        send_sample(16'd40000, 16'd20000, 14'd4095,  16'd16384, 1'b0);
        send_sample(16'd100,   16'd200,   14'd4097,  16'd16384, 1'b1);
        send_sample(16'd7,     16'd8,     14'd1000,  16'd16384, 1'b1);
        send_sample(16'd9,     16'd10,    14'd1000,  16'd16384, 1'b0);
        send_sample(16'd11,    16'd12,    14'd1000,  16'd16384, 1'b1);
        send_sample(16'd65535, 16'd0,     14'd1365,  16'd65535, 1'b0);
        send_sample(16'd0,     16'd65535, 14'd1365,  16'd65535, 1'b0);
        send_sample(16'd65535, 16'd65535, 14'd3000,  16'd65535, 1'b1);
        wait_idle();
    endtask

    task automatic test_offset_extremes();
        write_offset(16'd0);
        send_sample(16'd65535, 16'd65535, 14'd1024, 16'd65535, 1'b0);
        send_sample(16'd65535, 16'd0,     14'd1024, 16'd65535, 1'b0);
        send_sample(16'd0,     16'd65535, 14'd1024, 16'd65535, 1'b1);
        wait_idle();
        write_offset(16'd65535);
        send_sample(16'd0,     16'd0,     14'd1024, 16'd65535, 1'b0);
        send_sample(16'd0,     16'd65535, 14'd1024, 16'd65535, 1'b0);
        send_sample(16'd65535, 16'd0,     14'd1024, 16'd65535, 1'b1);
        wait_idle();
        write_offset(16'($urandom_range(0, 65535)));
        run_streams(6);
        wait_idle();
    endtask

    task automatic test_random_idling();
        int snd_modes[4] = '{0, 87, 0, 14};
        int rcv_modes[4] = '{0, 0, 87, 14};
        int m;
        for (m = 0; m < 4; m++) begin
            write_offset((m == 3) ? OFFSET_RESET : 16'($urandom_range(0, 65535)));
            snd_idle_pct  = snd_modes[m];
            rcv_stall_pct = rcv_modes[m];
            run_streams(45);
            wait_idle();
        end
    endtask

    task automatic test_backpressure();
        int k;
        snd_idle_pct  = 0;
        rcv_stall_pct = 0;
        hold_order <= hold_order + 1;
        for (k = 0; k < 12; k++) begin
            send_sample(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)), 14'd1024,
                        16'($urandom_range(0, 65535)), k == 11);
        end
        wait_idle();
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_offset_extremes();
        test_random_idling();
        test_backpressure();
        if (error_count == 0) begin
            $display("** stereo_linear_interp_resampler: PASSED **");
        end else begin
            $display("** stereo_linear_interp_resampler: FAILED **");
        end
        $finish;
    end

endmodule

FILE: stereo_linear_interp_resampler.f
rtl/core/slir_pkg.sv
rtl/core/slir_lane.sv
rtl/core/slir_seq.sv
rtl/core/stereo_linear_interp_resampler.sv
rtl/core/slir_checker.sv
sim/stereo_linear_interp_resampler_tb.sv
